### hw/rtl/dglbl_pkg.sv
// dglbl_pkg: shared types and constants of the linear dg bound limiter
// no dependencies; imported by the limiter core

package dglbl_pkg;

   // which side of the bound is enforced
   typedef enum logic {
      MODE_UPPER = 1'b0,
      MODE_LOWER = 1'b1
   } bound_mode_type;

   // configuration register indexes
   localparam int CSR_INDEX_BITS = 2;
   localparam logic [CSR_INDEX_BITS-1:0] REG_BOUND_MODE  = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_BOUND_VALUE = 2'd1;

   // bound after reset: 1.0 in the default q16.16 format
   localparam logic [63:0] BOUND_RESET_RAW = 64'd65536;

endpackage : dglbl_pkg

### hw/rtl/dglbl_frac_div.sv
// dglbl_frac_div: pipelined restoring divider, one quotient bit per stage
// gives floor((num << Q_BITS) / den) for num < den, with side data in lockstep

module dglbl_frac_div #(
   parameter int DEN_BITS  = 34,
   parameter int Q_BITS    = 16,
   parameter int SIDE_BITS = 161
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  logic [DEN_BITS-1:0]  in_num,
   input  logic [DEN_BITS-1:0]  in_den,
   input  logic [SIDE_BITS-1:0] in_side,
   output logic                 out_valid,
   input  logic                 out_ready,
   output logic [Q_BITS-1:0]    out_quo,
   output logic [SIDE_BITS-1:0] out_side
);

   logic                 vld_ff  [Q_BITS];
   logic [DEN_BITS-1:0]  rem_ff  [Q_BITS];
   logic [DEN_BITS-1:0]  den_ff  [Q_BITS];
   logic [Q_BITS-1:0]    quo_ff  [Q_BITS];
   logic [SIDE_BITS-1:0] side_ff [Q_BITS];

   logic                 prev_vld  [Q_BITS];
   logic [DEN_BITS-1:0]  prev_rem  [Q_BITS];
   logic [DEN_BITS-1:0]  prev_den  [Q_BITS];
   logic [Q_BITS-1:0]    prev_quo  [Q_BITS];
   logic [SIDE_BITS-1:0] prev_side [Q_BITS];

   // a stage may load when it is empty or its contents move on
   logic [Q_BITS:0] stage_en;

   assign stage_en[Q_BITS] = out_ready;
   assign in_ready         = stage_en[0];
   assign out_valid        = vld_ff[Q_BITS-1];
   assign out_quo          = quo_ff[Q_BITS-1];
   assign out_side         = side_ff[Q_BITS-1];

   for (genvar k = 0; k < Q_BITS; k++) begin : g_stage
      logic [DEN_BITS-1:0] shift_val;
      logic                take_bit;
      logic [DEN_BITS-1:0] rem_in;
      logic [Q_BITS-1:0]   quo_in;

      // stage input: the ports for the first stage, the prior stage otherwise
      if (k == 0) begin : g_first
         assign prev_vld[k]  = in_valid;
         assign prev_rem[k]  = in_num;
         assign prev_den[k]  = in_den;
         assign prev_quo[k]  = '0;
         assign prev_side[k] = in_side;
      end else begin : g_rest
         assign prev_vld[k]  = vld_ff[k-1];
         assign prev_rem[k]  = rem_ff[k-1];
         assign prev_den[k]  = den_ff[k-1];
         assign prev_quo[k]  = quo_ff[k-1];
         assign prev_side[k] = side_ff[k-1];
      end

      assign stage_en[k] = !vld_ff[k] || stage_en[k+1];

      // one restoring step: remainder stays below the divisor
      always_comb begin
         shift_val = {prev_rem[k][DEN_BITS-2:0], 1'b0};
         take_bit  = (shift_val >= prev_den[k]);
         rem_in    = take_bit ? (shift_val - prev_den[k]) : shift_val;
         quo_in    = {prev_quo[k][Q_BITS-2:0], take_bit};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else if (stage_en[k]) begin
            vld_ff[k] <= prev_vld[k];
         end
      end

      always_ff @(posedge clock) begin
         if (stage_en[k] && prev_vld[k]) begin
            rem_ff[k]  <= rem_in;
            den_ff[k]  <= prev_den[k];
            quo_ff[k]  <= quo_in;
            side_ff[k] <= prev_side[k];
         end
      end
   end

endmodule : dglbl_frac_div

### hw/rtl/dg_linear_bound_limiter_core.sv
// dg_linear_bound_limiter_core: bound-preserving limiter for linear dg cells
// depends on dglbl_pkg and dglbl_frac_div
//
// Usage
//   req_*  : one cell per transfer (mean, x slope, y slope, signed fixed point
//            with FRAC_BITS fraction bits); req_stall holds the sender off.
//   rsp_*  : one result per cell, in order: clamped mean, both slopes and
//            rsp_slopes_scaled when the slopes were scaled by |bound-mean|/l0.
//   csr_*  : register writes (0 = bound mode, 1 = bound value); csr_ready is
//            always high. Write only while no cell is in flight.
// Throughput: one cell per cycle unless rsp_stall backs up every stage, with no dependence between cells.
// Pipeline: two front stages, the divider that resolves one quotient bit per
//   stage, a multiply stage and the output register.
// Reset: empties the pipeline, sets upper-bound mode and bound 1.0.
// Stall: a stalled result holds; earlier stages keep filling bubbles, and
//   req_stall rises only once every stage is occupied.

module dg_linear_bound_limiter_core
   import dglbl_pkg::*;
#(
   parameter int WORD_BITS = 32,
   parameter int FRAC_BITS = 16
) (
   input  logic                        clock,
   input  logic                        reset,

   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic signed [WORD_BITS-1:0] req_mean_in,
   input  logic signed [WORD_BITS-1:0] req_slope_x_in,
   input  logic signed [WORD_BITS-1:0] req_slope_y_in,

   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic signed [WORD_BITS-1:0] rsp_mean_out,
   output logic signed [WORD_BITS-1:0] rsp_slope_x_out,
   output logic signed [WORD_BITS-1:0] rsp_slope_y_out,
   output logic                        rsp_slopes_scaled,

   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [WORD_BITS-1:0]        csr_data
);

   localparam int SUM_BITS  = WORD_BITS + 1;
   localparam int DEN_BITS  = WORD_BITS + 2;
   localparam int SIDE_BITS = 5 * WORD_BITS + 1;
   localparam int PROD_BITS = WORD_BITS + FRAC_BITS;
   localparam logic signed [WORD_BITS-1:0] BOUND_RESET = WORD_BITS'(BOUND_RESET_RAW);

   // configuration registers
   bound_mode_type              bound_mode_ff;
   logic signed [WORD_BITS-1:0] bound_value_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         bound_mode_ff  <= MODE_UPPER;
         bound_value_ff <= BOUND_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_BOUND_MODE:  bound_mode_ff  <= bound_mode_type'(csr_data[0]);
            REG_BOUND_VALUE: bound_value_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // stage enables, from the output back to the input
   logic out_en, m_en, s2_en, s1_en, div_in_ready;
   logic rsp_valid_ff, m_vld_ff, s2_vld_ff, s1_vld_ff;

   assign out_en    = !rsp_valid_ff || !rsp_stall;
   assign m_en      = !m_vld_ff || out_en;
   assign s2_en     = !s2_vld_ff || div_in_ready;
   assign s1_en     = !s1_vld_ff || s2_en;
   assign req_stall = !s1_en;

   // stage 1: clamp the mean, form slope sum and difference
   logic signed [WORD_BITS-1:0] s1_mean_in, s1_mean_ff, s1_sx_ff, s1_sy_ff;
   logic signed [SUM_BITS-1:0]  s1_sum_in, s1_dif_in, s1_sum_ff, s1_dif_ff;

   always_comb begin
      if (bound_mode_ff == MODE_UPPER) begin
         s1_mean_in = (req_mean_in > bound_value_ff) ? bound_value_ff : req_mean_in;
      end else begin
         s1_mean_in = (req_mean_in < bound_value_ff) ? bound_value_ff : req_mean_in;
      end
      s1_sum_in = {req_slope_x_in[WORD_BITS-1], req_slope_x_in}
                + {req_slope_y_in[WORD_BITS-1], req_slope_y_in};
      s1_dif_in = {req_slope_x_in[WORD_BITS-1], req_slope_x_in}
                - {req_slope_y_in[WORD_BITS-1], req_slope_y_in};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else if (s1_en) begin
         s1_vld_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_en && req_valid) begin
         s1_mean_ff <= s1_mean_in;
         s1_sx_ff   <= req_slope_x_in;
         s1_sy_ff   <= req_slope_y_in;
         s1_sum_ff  <= s1_sum_in;
         s1_dif_ff  <= s1_dif_in;
      end
   end

   // stage 2: distance to the bound, spread l0 and slope magnitudes
   logic signed [SUM_BITS-1:0]  s2_gap_wide;
   logic [SUM_BITS-1:0]         s2_abs_sum, s2_abs_dif, s2_spread_max;
   logic [WORD_BITS-1:0]        s2_diff_in, s2_abs_x_in, s2_abs_y_in;
   logic [DEN_BITS-1:0]         s2_l0_in;
   logic signed [WORD_BITS-1:0] s2_mean_ff, s2_sx_ff, s2_sy_ff;
   logic [WORD_BITS-1:0]        s2_diff_ff, s2_abs_x_ff, s2_abs_y_ff;
   logic [DEN_BITS-1:0]         s2_l0_ff;

   always_comb begin
      if (bound_mode_ff == MODE_UPPER) begin
         s2_gap_wide = {bound_value_ff[WORD_BITS-1], bound_value_ff}
                     - {s1_mean_ff[WORD_BITS-1], s1_mean_ff};
      end else begin
         s2_gap_wide = {s1_mean_ff[WORD_BITS-1], s1_mean_ff}
                     - {bound_value_ff[WORD_BITS-1], bound_value_ff};
      end
      s2_diff_in    = s2_gap_wide[WORD_BITS-1:0];
      s2_abs_sum    = s1_sum_ff[SUM_BITS-1] ? -s1_sum_ff : s1_sum_ff;
      s2_abs_dif    = s1_dif_ff[SUM_BITS-1] ? -s1_dif_ff : s1_dif_ff;
      s2_spread_max = (s2_abs_sum > s2_abs_dif) ? s2_abs_sum : s2_abs_dif;
      s2_l0_in      = {s2_spread_max, 1'b0};
      s2_abs_x_in   = s1_sx_ff[WORD_BITS-1] ? -s1_sx_ff : s1_sx_ff;
      s2_abs_y_in   = s1_sy_ff[WORD_BITS-1] ? -s1_sy_ff : s1_sy_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_vld_ff <= 1'b0;
      end else if (s2_en) begin
         s2_vld_ff <= s1_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_en && s1_vld_ff) begin
         s2_mean_ff  <= s1_mean_ff;
         s2_sx_ff    <= s1_sx_ff;
         s2_sy_ff    <= s1_sy_ff;
         s2_diff_ff  <= s2_diff_in;
         s2_l0_ff    <= s2_l0_in;
         s2_abs_x_ff <= s2_abs_x_in;
         s2_abs_y_ff <= s2_abs_y_in;
      end
   end

   // divider: quotient |bound-mean| / l0, only used when the bound is crossed
   logic                 cross_in;
   logic [DEN_BITS-1:0]  div_num;
   logic [SIDE_BITS-1:0] div_side_in, div_side_out;
   logic                 div_out_valid;
   logic [FRAC_BITS-1:0] div_quo;

   assign div_num     = {2'b00, s2_diff_ff};
   assign cross_in    = (s2_l0_ff > div_num);
   assign div_side_in = {s2_mean_ff, s2_sx_ff, s2_sy_ff, s2_abs_x_ff, s2_abs_y_ff, cross_in};

   dglbl_frac_div #(
      .DEN_BITS  (DEN_BITS),
      .Q_BITS    (FRAC_BITS),
      .SIDE_BITS (SIDE_BITS)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s2_vld_ff),
      .in_ready  (div_in_ready),
      .in_num    (div_num),
      .in_den    (s2_l0_ff),
      .in_side   (div_side_in),
      .out_valid (div_out_valid),
      .out_ready (m_en),
      .out_quo   (div_quo),
      .out_side  (div_side_out)
   );

   // multiply stage: slope magnitudes times the quotient
   logic signed [WORD_BITS-1:0] d_mean, d_sx, d_sy;
   logic [WORD_BITS-1:0]        d_abs_x, d_abs_y;
   logic                        d_cross;
   logic [PROD_BITS-1:0]        m_prod_x_in, m_prod_y_in, m_prod_x_ff, m_prod_y_ff;
   logic signed [WORD_BITS-1:0] m_mean_ff, m_sx_ff, m_sy_ff;
   logic                        m_cross_ff;

   assign {d_mean, d_sx, d_sy, d_abs_x, d_abs_y, d_cross} = div_side_out;
   assign m_prod_x_in = PROD_BITS'(d_abs_x) * PROD_BITS'(div_quo);
   assign m_prod_y_in = PROD_BITS'(d_abs_y) * PROD_BITS'(div_quo);

   always_ff @(posedge clock) begin
      if (reset) begin
         m_vld_ff <= 1'b0;
      end else if (m_en) begin
         m_vld_ff <= div_out_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (m_en && div_out_valid) begin
         m_mean_ff   <= d_mean;
         m_sx_ff     <= d_sx;
         m_sy_ff     <= d_sy;
         m_cross_ff  <= d_cross;
         m_prod_x_ff <= m_prod_x_in;
         m_prod_y_ff <= m_prod_y_in;
      end
   end

   // output stage: drop fraction bits, restore sign, pick scaled or original
   logic [WORD_BITS-1:0]        o_mag_x, o_mag_y;
   logic signed [WORD_BITS-1:0] o_sx_in, o_sy_in;
   logic signed [WORD_BITS-1:0] rsp_mean_ff, rsp_sx_ff, rsp_sy_ff;
   logic                        rsp_scaled_ff;

   always_comb begin
      o_mag_x = m_prod_x_ff[PROD_BITS-1:FRAC_BITS];
      o_mag_y = m_prod_y_ff[PROD_BITS-1:FRAC_BITS];
      if (m_cross_ff) begin
         o_sx_in = m_sx_ff[WORD_BITS-1] ? -o_mag_x : o_mag_x;
         o_sy_in = m_sy_ff[WORD_BITS-1] ? -o_mag_y : o_mag_y;
      end else begin
         o_sx_in = m_sx_ff;
         o_sy_in = m_sy_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_en) begin
         rsp_valid_ff <= m_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (out_en && m_vld_ff) begin
         rsp_mean_ff   <= m_mean_ff;
         rsp_sx_ff     <= o_sx_in;
         rsp_sy_ff     <= o_sy_in;
         rsp_scaled_ff <= m_cross_ff;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_mean_out      = rsp_mean_ff;
   assign rsp_slope_x_out   = rsp_sx_ff;
   assign rsp_slope_y_out   = rsp_sy_ff;
   assign rsp_slopes_scaled = rsp_scaled_ff;

`ifndef ASSERT_OFF
   // the delivered mean always respects the bound
   a_mean_in_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |->
         ((bound_mode_ff == MODE_UPPER) && (rsp_mean_ff <= bound_value_ff)) ||
         ((bound_mode_ff == MODE_LOWER) && (rsp_mean_ff >= bound_value_ff)))
      else $error("limited mean lies beyond the bound");

   // the input is held off only when the pipeline is backed up to the output
   a_stall_only_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid_ff && rsp_stall))
      else $error("input stalled while the pipeline can still advance");

   // a new result only comes from an occupied multiply stage
   a_result_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(m_vld_ff))
      else $error("result appeared without an item in the multiply stage");
`endif

endmodule : dg_linear_bound_limiter_core
